/* hdl/pes_pkg.sv */
// pes_pkg: shared constants for the product-except-self block
// no dependencies; used by the channel interfaces and the top level
package pes_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAX_LENGTH = 64;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int CNT_W      = $clog2(MAX_LENGTH + 1);

    localparam logic [DATA_WIDTH-1:0] WORD_ONE = DATA_WIDTH'(1);

endpackage

/* hdl/pes_if.sv */
// pes_in_if / pes_out_if: valid-ready channels for elements and results
// depends on pes_pkg for the data width
interface pes_in_if import pes_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] element_value;
    logic                         is_last_element;

    modport source (output valid, element_value, is_last_element, input ready);
    modport sink   (input valid, element_value, is_last_element, output ready);
endinterface

interface pes_out_if import pes_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] product_others;
    logic                         is_last_result;

    modport source (output valid, product_others, is_last_result, input ready);
    modport sink   (input valid, product_others, is_last_result, output ready);
endinterface

/* hdl/product_except_self.sv */
// product_except_self: for each element of a vector, the product of all others
// elements are stored as they are transferred; a backward pass then stores suffix products
// and a forward pass multiplies the running prefix product by each stored suffix product,
// held while the output register is full; no element is taken during the two passes;
// reset clears control state, not the memories
// depends on pes_pkg and pes_if
module product_except_self import pes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pes_in_if.sink      elements,
    pes_out_if.source   results
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_BWD  = 3'b010,
        ST_FWD  = 3'b100
    } pes_state_t;

    // storage
    logic [DATA_WIDTH-1:0] elem_mem [MAX_LENGTH];
    logic [DATA_WIDTH-1:0] suf_mem  [MAX_LENGTH];
    logic [DATA_WIDTH-1:0] elem_rd_reg;
    logic [DATA_WIDTH-1:0] suf_rd_reg;

    // control and datapath registers
    pes_state_t            state_reg,     state_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic [ADDR_W-1:0]     idx_reg,       idx_next;
    logic [ADDR_W-1:0]     last_idx_reg,  last_idx_next;
    logic                  issuing_reg,   issuing_next;
    logic                  pend_reg,      pend_next;
    logic                  pend_last_reg, pend_last_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [DATA_WIDTH-1:0] run_reg,       run_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  out_last_reg;

    logic                  in_fire;
    logic                  full;
    logic                  out_free;
    logic                  advance;
    logic                  rd_en;
    logic                  consume;
    logic                  elem_we;
    logic                  suf_we;
    logic                  out_load;
    logic [2*DATA_WIDTH-1:0] run_prod_full;
    logic [2*DATA_WIDTH-1:0] out_prod_full;
    logic [DATA_WIDTH-1:0] run_prod;
    logic [DATA_WIDTH-1:0] out_prod;

    // handshake and pipeline control
    assign elements.ready = (state_reg == ST_LOAD);
    assign in_fire        = elements.valid && elements.ready;
    assign full           = (count_reg == CNT_W'(MAX_LENGTH));
    assign out_free       = !out_valid_reg || results.ready;
    assign advance        = (state_reg == ST_FWD) ? (!pend_reg || out_free) : 1'b1;
    assign rd_en          = (state_reg != ST_LOAD) && issuing_reg && advance;
    assign consume        = (state_reg != ST_LOAD) && pend_reg && advance;
    assign elem_we        = in_fire && !full;
    assign suf_we         = (state_reg == ST_BWD) && consume;
    assign out_load       = (state_reg == ST_FWD) && consume;

    // wrapping multiplies: running product and result
    assign run_prod_full = run_reg * elem_rd_reg;
    assign out_prod_full = run_reg * suf_rd_reg;
    assign run_prod      = run_prod_full[DATA_WIDTH-1:0];
    assign out_prod      = out_prod_full[DATA_WIDTH-1:0];

    // element memory
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[count_reg[ADDR_W-1:0]] <= elements.element_value;
        end
        if (rd_en)
        begin
            elem_rd_reg <= elem_mem[idx_reg];
        end
    end

    // suffix product memory
    always_ff @(posedge clk)
    begin
        if (suf_we)
        begin
            suf_mem[pend_addr_reg] <= run_reg;
        end
        if (rd_en)
        begin
            suf_rd_reg <= suf_mem[idx_reg];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        issuing_next   = issuing_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        pend_addr_next = pend_addr_reg;
        run_next       = run_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (elements.is_last_element)
                    begin
                        state_next    = ST_BWD;
                        idx_next      = full ? ADDR_W'(MAX_LENGTH - 1)
                                             : count_reg[ADDR_W-1:0];
                        last_idx_next = full ? ADDR_W'(MAX_LENGTH - 1)
                                             : count_reg[ADDR_W-1:0];
                        issuing_next  = 1'b1;
                        run_next      = WORD_ONE;
                    end
                end
            end
            ST_BWD:
            begin
                // walk down from the last position
                pend_next = rd_en;
                if (rd_en)
                begin
                    pend_addr_next = idx_reg;
                    pend_last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - ADDR_W'(1);
                    end
                end
                if (consume)
                begin
                    run_next = run_prod;
                    if (pend_last_reg)
                    begin
                        state_next   = ST_FWD;
                        run_next     = WORD_ONE;
                        idx_next     = '0;
                        issuing_next = 1'b1;
                    end
                end
            end
            ST_FWD:
            begin
                // walk up from position zero, held while the output stage is full
                if (advance)
                begin
                    pend_next = rd_en;
                end
                if (rd_en)
                begin
                    pend_last_next = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
                if (consume)
                begin
                    run_next = run_prod;
                    if (pend_last_reg)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        run_next   = WORD_ONE;
                    end
                end
            end
            default:
            begin
                state_next   = ST_LOAD;
                count_next   = '0;
                issuing_next = 1'b0;
                pend_next    = 1'b0;
                run_next     = WORD_ONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            pend_addr_reg <= '0;
            run_reg       <= WORD_ONE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            pend_addr_reg <= pend_addr_next;
            run_reg       <= run_next;
        end
    end

    // output register
    assign out_valid_next = out_load ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_prod;
            out_last_reg <= pend_last_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.product_others = out_data_reg;
    assign results.is_last_result = out_last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LENGTH))
        else $error("element count beyond store depth");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (!pend_reg && !issuing_reg))
        else $error("memory walk active while loading");

    a_bwd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BWD) |-> (issuing_reg || pend_reg))
        else $error("backward pass stalled with nothing in flight");

    a_fwd_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FWD && consume && pend_last_reg)
            |=> (state_reg == ST_LOAD && count_reg == '0 && out_valid_reg && out_last_reg))
        else $error("vector end not followed by a clean return to loading");

endmodule
